// ===== rtl/bpa_pkg.sv =====
// Package for the buddy page allocator: field widths, codes and FSM state type.
// No dependencies.
package bpa_pkg;

  localparam int TOP_ORDER_DEF  = 10;
  localparam int MAX_PAGES_DEF  = 1024;
  localparam int FRAME_BITS_DEF = 20;

  localparam int KIND_W  = 2;
  localparam int ORDER_W = 4;
  localparam int CNT_W   = 16;
  localparam int PAGE_W  = 20;
  localparam int STAT_W  = 2;
  localparam int NPG_W   = 11;
  localparam int CFG_W   = 20;
  localparam int CIDX_W  = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_COUNT = 2'd2,
    KIND_FREE  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_OOM  = 2'd1,
    ST_BAD  = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  localparam logic [CIDX_W-1:0] REG_BASE  = 1'd0;
  localparam logic [CIDX_W-1:0] REG_PAGES = 1'd1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT_CLR,
    S_INIT_STEP,
    S_AL_SCAN,
    S_AL_RD,
    S_AL_POP,
    S_AL_SPLIT,
    S_FR_CHK,
    S_FR_HEAD,
    S_FR_RD,
    S_FR_CMP,
    S_FR_UNRD,
    S_FR_UNLINK,
    S_FR_PUSH,
    S_OUT
  } state_t;

endpackage

// ===== rtl/bpa_link_ram.sv =====
// Next-link store of the buddy allocator, one entry per managed page.
// Depends on nothing; one write and one registered read per cycle.
module bpa_link_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/buddy_page_allocator_core.sv =====
// Top level of the buddy page allocator: sequencer, list heads and link store.
// Depends on bpa_pkg and bpa_link_ram.
module buddy_page_allocator_core #(
  parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bpa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [1:0]                   in_tuser,   // kind
  input  logic [39:0]                  in_tdata,   // block_order[3:0], page_count[19:4], block_page[39:20]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [39:0]                  out_tdata   // status[1:0], result_page[21:2], free_pages[32:22]
);
  // One item at a time. Everything runs on a sequencer and a link RAM with one write
  // port and one registered read port:
  //   init   : clear all heads, then push the blocks one at a time (<= ~20)
  //            and stop once the run is used up
  //   alloc  : scan the orders upward, read the link and pop, then split down to the order
  //   free   : 2 checks, then per order walk the list for the buddy, and unlink and merge
  //            when found; each walk is bounded by MAX_PAGES elements.
  // The result is held in an output register and the block becomes ready when it is taken.
  // The free count saturates and frames wrap at the frame width; frame 0 fails a free.

  import bpa_pkg::*;

  localparam int MAX_PAGES  = MAX_PAGES_DEF;
  localparam int FRAME_BITS = FRAME_BITS_DEF;
  localparam int IW = $clog2(MAX_PAGES + 1);  // index incl. null
  localparam int AW = $clog2(MAX_PAGES);
  localparam int OW = $clog2(TOP_ORDER + 2);
  localparam int WW = FRAME_BITS + 2;          // working width for frames
  localparam logic [IW-1:0] NULL_IX = IW'(MAX_PAGES);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  base_cfg_r;
  logic [NPG_W-1:0]  pages_cfg_r;
  logic [WW-1:0]     run_base_r, run_base_nxt;
  logic [WW-1:0]     run_pages_r, run_pages_nxt;
  logic [IW-1:0]     head_r [TOP_ORDER+1];
  logic [NPG_W-1:0]  free_r, free_nxt;

  logic [OW-1:0]     ord_r, ord_nxt;        // target order
  logic [OW-1:0]     cur_r, cur_nxt;        // working order
  logic [WW-1:0]     addr_r, addr_nxt;      // init cursor / free address
  logic [WW-1:0]     cnt_r, cnt_nxt;        // init remaining
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     prev_r, prev_nxt;
  logic [IW-1:0]     walk_r, walk_nxt;
  logic [IW:0]       steps_r, steps_nxt;
  status_t           st_r, st_nxt;
  logic [PAGE_W-1:0] res_r, res_nxt;

  // head update, one per cycle
  logic              hwe;
  logic [OW-1:0]     hsel;
  logic [IW-1:0]     hval;
  logic              hclr;

  logic              lwe;
  logic [AW-1:0]     lwa, lra;
  logic [IW-1:0]     lwd, lrd;

  bpa_link_ram #(.DEPTH(MAX_PAGES), .AW(AW), .DW(IW)) u_links (
    .clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd)
  );

  logic [ORDER_W-1:0] in_ord;
  logic [CNT_W-1:0]   in_cnt;
  logic [PAGE_W-1:0]  in_page;
  assign in_ord  = in_tdata[3:0];
  assign in_cnt  = in_tdata[19:4];
  assign in_page = in_tdata[39:20];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, free_r, res_r, st_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r  <= '0;
      pages_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:  base_cfg_r  <= cfg_wdata;
        REG_PAGES: pages_cfg_r <= cfg_wdata[NPG_W-1:0];
        default: ;
      endcase
    end
  end

  // head of the working order
  logic [IW-1:0] head_cur;
  assign head_cur = head_r[cur_r];

  // shared arithmetic
  logic [WW-1:0] sz_cur;
  logic [WW-1:0] frame_sum;
  assign sz_cur    = WW'(1) << cur_r;
  assign frame_sum = run_base_r + WW'(walk_r);

  // count to order (priority encode, narrow)
  function automatic logic [OW-1:0] cnt_order(input logic [CNT_W-1:0] n);
    logic [OW-1:0] o;
    o = '0;
    for (int k = TOP_ORDER; k >= 1; k--) begin
      if ({1'b0, n} > (17'(1) << (k - 1))) begin
        o = OW'(k);
        break;
      end
    end
    return o;
  endfunction

  logic [WW-1:0] init_cnt;
  always_comb begin
    logic [WW-1:0] c;
    logic [WW-1:0] space;
    c = (WW'(pages_cfg_r) > WW'(MAX_PAGES)) ? WW'(MAX_PAGES) : WW'(pages_cfg_r);
    space = (WW'(1) << FRAME_BITS) - WW'(base_cfg_r);
    if (WW'(base_cfg_r) >= (WW'(1) << FRAME_BITS)) begin
      c = '0;
    end else if (c > space) begin
      c = space;
    end
    init_cnt = c;
  end

  // init block order: largest order fitting count and aligned
  logic [OW-1:0] init_o;
  always_comb begin
    init_o = '0;
    for (int k = TOP_ORDER; k >= 1; k--) begin
      if ((WW'(1) << k) <= cnt_r && (addr_r & ((WW'(1) << k) - WW'(1))) == '0) begin
        init_o = OW'(k);
        break;
      end
    end
  end

  function automatic logic [NPG_W-1:0] fadd(input logic [NPG_W-1:0] f, input logic [WW-1:0] n);
    logic [WW:0] t;
    t = {1'b0, WW'(f)} + {1'b0, n};
    return (t > (WW+1)'(MAX_PAGES)) ? NPG_W'(MAX_PAGES) : NPG_W'(t);
  endfunction

  always_comb begin
    state_nxt     = state_r;
    run_base_nxt  = run_base_r;
    run_pages_nxt = run_pages_r;
    free_nxt      = free_r;
    ord_nxt       = ord_r;
    cur_nxt       = cur_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    walk_nxt      = walk_r;
    steps_nxt     = steps_r;
    st_nxt        = st_r;
    res_nxt       = res_r;
    hwe = 1'b0; hsel = cur_r; hval = NULL_IX; hclr = 1'b0;
    lwe = 1'b0; lwa = '0; lwd = '0; lra = walk_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          st_nxt   = ST_DONE;
          res_nxt  = '0;
          unique case (kind_t'(in_tuser))
            KIND_INIT: begin
              run_base_nxt  = WW'(base_cfg_r);
              run_pages_nxt = init_cnt;
              addr_nxt      = WW'(base_cfg_r);
              cnt_nxt       = init_cnt;
              free_nxt      = '0;
              state_nxt     = S_INIT_CLR;
            end
            KIND_ALLOC, KIND_COUNT: begin
              logic [OW-1:0] o;
              logic bad;
              if (kind_t'(in_tuser) == KIND_ALLOC) begin
                o   = OW'(in_ord);
                bad = (32'(in_ord) > TOP_ORDER);
              end else begin
                o   = cnt_order(in_cnt);
                bad = (in_cnt == '0) || (32'(in_cnt) > (32'(1) << TOP_ORDER));
              end
              ord_nxt = o;
              cur_nxt = o;
              if (bad) begin
                st_nxt    = ST_BAD;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_AL_SCAN;
              end
            end
            default: begin
              ord_nxt   = OW'(in_ord);
              cur_nxt   = OW'(in_ord);
              addr_nxt  = WW'(in_page);
              if (in_page == '0 || 32'(in_ord) > TOP_ORDER ||
                  WW'(in_page) < run_base_r) begin
                st_nxt    = ST_BAD;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_FR_CHK;
              end
            end
          endcase
        end
      end

      S_INIT_CLR: begin
        hclr      = 1'b1;
        state_nxt = S_INIT_STEP;
      end

      S_INIT_STEP: begin
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          // push block at addr of order init_o
          idx_nxt  = IW'(addr_r - run_base_r);
          hwe  = 1'b1; hsel = init_o; hval = IW'(addr_r - run_base_r);
          lwe  = 1'b1; lwa = AW'(addr_r - run_base_r); lwd = head_r[init_o];
          free_nxt = fadd(free_r, WW'(1) << init_o);
          addr_nxt = addr_r + (WW'(1) << init_o);
          cnt_nxt  = cnt_r - (WW'(1) << init_o);
        end
      end

      S_AL_SCAN: begin
        if (32'(cur_r) > TOP_ORDER) begin
          st_nxt    = ST_OOM;
          state_nxt = S_OUT;
        end else if (head_cur == NULL_IX) begin
          cur_nxt = cur_r + OW'(1);
        end else begin
          idx_nxt   = head_cur;
          walk_nxt  = head_cur;
          state_nxt = S_AL_RD;
        end
      end

      S_AL_RD: begin
        lra       = idx_r[AW-1:0];
        state_nxt = S_AL_POP;
      end

      S_AL_POP: begin
        hwe = 1'b1; hsel = cur_r;
        hval = (idx_r < NULL_IX) ? lrd : NULL_IX;
        state_nxt = S_AL_SPLIT;
      end

      S_AL_SPLIT: begin
        if (cur_r == ord_r) begin
          logic [WW-1:0] n;
          n = WW'(1) << ord_r;
          free_nxt  = (WW'(free_r) < n) ? '0 : free_r - NPG_W'(n);
          res_nxt   = PAGE_W'(run_base_r + WW'(idx_r));
          state_nxt = S_OUT;
        end else begin
          logic [OW-1:0] c;
          logic [IW-1:0] b;
          c = cur_r - OW'(1);
          b = idx_r + IW'(WW'(1) << c);
          cur_nxt = c;
          hwe = 1'b1; hsel = c; hval = b;
          lwe = (b < NULL_IX); lwa = AW'(b); lwd = head_r[c];
        end
      end

      S_FR_CHK: begin
        logic [WW-1:0] off;
        off = addr_r - run_base_r;
        if ((addr_r & (sz_cur - WW'(1))) != '0 || off >= run_pages_r ||
            sz_cur > run_pages_r - off) begin
          st_nxt    = ST_BAD;
          state_nxt = S_OUT;
        end else begin
          free_nxt  = fadd(free_r, sz_cur);
          state_nxt = S_FR_HEAD;
        end
      end

      S_FR_HEAD: begin
        if (32'(cur_r) >= TOP_ORDER) begin
          state_nxt = S_FR_PUSH;
        end else begin
          prev_nxt  = NULL_IX;
          walk_nxt  = head_cur;
          steps_nxt = '0;
          state_nxt = S_FR_CMP;
        end
      end

      S_FR_CMP: begin
        if (walk_r == NULL_IX || 32'(steps_r) >= MAX_PAGES) begin
          state_nxt = S_FR_PUSH;
        end else if (frame_sum == (addr_r ^ sz_cur)) begin
          state_nxt = S_FR_UNRD;
        end else begin
          state_nxt = S_FR_RD;
        end
      end

      S_FR_RD: begin
        // advance along the list
        prev_nxt  = walk_r;
        walk_nxt  = lrd;
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_FR_CMP;
      end

      S_FR_UNRD: begin
        state_nxt = S_FR_UNLINK;
      end

      S_FR_UNLINK: begin
        logic [IW-1:0] nx;
        nx = lrd;
        if (prev_r == NULL_IX) begin
          hwe = 1'b1; hsel = cur_r; hval = nx;
        end else begin
          lwe = 1'b1; lwa = AW'(prev_r); lwd = nx;
        end
        if ((addr_r ^ sz_cur) < addr_r) begin
          addr_nxt = addr_r ^ sz_cur;
        end
        cur_nxt   = cur_r + OW'(1);
        state_nxt = S_FR_HEAD;
      end

      S_FR_PUSH: begin
        logic [IW-1:0] ix;
        ix = IW'(addr_r - run_base_r);
        hwe = 1'b1; hsel = cur_r; hval = ix;
        lwe = (ix < NULL_IX); lwa = AW'(ix); lwd = head_cur;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '0;
      run_base_r  <= '0;
      run_pages_r <= '0;
      for (int k = 0; k <= TOP_ORDER; k++) begin
        head_r[k] <= NULL_IX;
      end
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      run_base_r  <= run_base_nxt;
      run_pages_r <= run_pages_nxt;
      if (hclr) begin
        for (int k = 0; k <= TOP_ORDER; k++) begin
          head_r[k] <= NULL_IX;
        end
      end else if (hwe) begin
        head_r[hsel] <= hval;
      end
    end
  end

  always_ff @(posedge clk) begin
    ord_r   <= ord_nxt;
    cur_r   <= cur_nxt;
    addr_r  <= addr_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    prev_r  <= prev_nxt;
    walk_r  <= walk_nxt;
    steps_r <= steps_nxt;
    st_r    <= st_nxt;
    res_r   <= res_nxt;
  end
endmodule

// ===== test/bpa_result_checker.sv =====
// Result checker for the buddy page allocator: watches the config port and
// both streams, predicts each reply from its own copy of the free lists and
// compares. Depends on bpa_pkg.
module bpa_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bpa_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [1:0]                 in_tuser,
  input  logic [39:0]                in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [39:0]                out_tdata,
  output int                         fail_count,
  output int                         replies_owed
);

  import bpa_pkg::*;

  localparam int TOP_ORD = TOP_ORDER_DEF;
  localparam int NPAGES  = MAX_PAGES_DEF;
  localparam longint SPACE = longint'(1) << FRAME_BITS_DEF;
  localparam int NIL     = NPAGES;

  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] page;
    logic [NPG_W-1:0]  free_pages;
  } reply_t;

  reply_t replies_due[$];

  int     heads [0:TOP_ORD];
  int     links [0:NPAGES-1];
  int     free_cnt;
  longint reg_base, reg_pages, run_base, run_pages;

  function automatic void push_block(int o, int idx);
    if (idx < NPAGES) links[idx] = heads[o];
    heads[o] = idx;
  endfunction

  function automatic int link_at(int idx);
    return (idx < NPAGES) ? links[idx] : NIL;
  endfunction

  function automatic void add_pages(longint n);
    free_cnt = (free_cnt + n > NPAGES) ? NPAGES : int'(free_cnt + n);
  endfunction

  function automatic void rebuild_lists();
    longint cnt, addr, sz;
    int o;
    cnt  = (reg_pages > NPAGES) ? NPAGES : reg_pages;
    addr = reg_base;
    if (cnt > SPACE - addr) cnt = SPACE - addr;
    run_base  = addr;
    run_pages = cnt;
    free_cnt  = 0;
    for (int i = 0; i <= TOP_ORD; i++) heads[i] = NIL;
    while (cnt > 0) begin
      o = TOP_ORD;
      while (o > 0) begin
        sz = longint'(1) << o;
        if (sz <= cnt && (addr & (sz - 1)) == 0) break;
        o--;
      end
      sz = longint'(1) << o;
      push_block(o, int'(addr - run_base));
      add_pages(sz);
      addr += sz;
      cnt  -= sz;
    end
  endfunction

  function automatic status_t take_block(int ord, output longint frame);
    int cur, idx;
    frame = 0;
    if (ord > TOP_ORD) return ST_BAD;
    cur = ord;
    while (cur <= TOP_ORD && heads[cur] == NIL) cur++;
    if (cur > TOP_ORD) return ST_OOM;
    idx = heads[cur];
    heads[cur] = link_at(idx);
    while (cur > ord) begin
      cur--;
      push_block(cur, idx + (1 << cur));
    end
    free_cnt = (free_cnt < (1 << ord)) ? 0 : free_cnt - (1 << ord);
    frame = (run_base + idx) & (SPACE - 1);
    return ST_DONE;
  endfunction

  function automatic status_t give_back(longint addr, int ord);
    longint off, mate;
    int prv, cur, steps;
    bit hit;
    if (addr == 0 || ord > TOP_ORD || addr < run_base) return ST_BAD;
    if ((addr & ((longint'(1) << ord) - 1)) != 0) return ST_BAD;
    off = addr - run_base;
    if (off >= run_pages || (longint'(1) << ord) > run_pages - off) return ST_BAD;
    add_pages(longint'(1) << ord);
    while (ord < TOP_ORD) begin
      mate  = addr ^ (longint'(1) << ord);
      prv   = NIL;
      cur   = heads[ord];
      steps = 0;
      hit   = 0;
      // walk is bounded so a cycle left by a double free still ends
      while (cur != NIL && steps < NPAGES) begin
        if (run_base + cur == mate) begin
          hit = 1;
          break;
        end
        prv = cur;
        cur = link_at(cur);
        steps++;
      end
      if (!hit) break;
      if (prv == NIL) heads[ord] = link_at(cur);
      else if (prv < NPAGES) links[prv] = link_at(cur);
      if (mate < addr) addr = mate;
      ord++;
    end
    push_block(ord, int'(addr - run_base));
    return ST_DONE;
  endfunction

  function automatic reply_t predict_reply(kind_t kind, logic [39:0] d);
    reply_t r;
    longint frame, cnt;
    int ord;
    frame = 0;
    r.status = ST_DONE;
    cnt = d[19:4];
    case (kind)
      KIND_INIT:  rebuild_lists();
      KIND_ALLOC: r.status = take_block(int'(d[3:0]), frame);
      KIND_COUNT: begin
        if (cnt == 0) r.status = ST_BAD;
        else begin
          ord = 0;
          if (cnt > (longint'(1) << TOP_ORD)) ord = TOP_ORD + 1;
          else while ((longint'(1) << ord) < cnt) ord++;
          r.status = take_block(ord, frame);
        end
      end
      default:    r.status = give_back(longint'(d[39:20]), int'(d[3:0]));
    endcase
    r.page       = frame[PAGE_W-1:0];
    r.free_pages = free_cnt[NPG_W-1:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign replies_owed = replies_due.size();

  always @(posedge clk) begin
    reply_t seen, want;
    if (!rst_n) begin
      for (int i = 0; i <= TOP_ORD; i++) heads[i] = NIL;
      for (int i = 0; i < NPAGES; i++) links[i] = 0;
      free_cnt  = 0;
      reg_base  = 0;
      reg_pages = 0;
      run_base  = 0;
      run_pages = 0;
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BASE) reg_base = cfg_wdata;
        else reg_pages = cfg_wdata[NPG_W-1:0];
      end
      if (in_tvalid && in_tready)
        replies_due.push_back(predict_reply(kind_t'(in_tuser), in_tdata));
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[1:0], out_tdata[21:2], out_tdata[32:22]};
        if (replies_due.size() == 0) begin
          report("replies outstanding", 0, 1);
        end else begin
          want = replies_due.pop_front();
          if (seen.status != want.status) report("status", seen.status, want.status);
          if (seen.page != want.page) report("result_page", seen.page, want.page);
          if (seen.free_pages != want.free_pages)
            report("free_pages", seen.free_pages, want.free_pages);
        end
      end
    end
  end

endmodule

// ===== test/buddy_page_allocator_core_tb.sv =====
// Testbench top for the buddy page allocator: clock, reset, config writes and
// request stimulus under several idle patterns. Depends on bpa_pkg,
// buddy_page_allocator_core and bpa_result_checker.
module buddy_page_allocator_core_tb;
  import bpa_pkg::*;

  localparam int STALL_LIMIT = 200000;

  typedef struct {
    longint page;
    int     ord;
  } held_block_t;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [1:0]        in_tuser = '0;   // kind
  logic [39:0]       in_tdata = '0;   // block_order[3:0], page_count[19:4], block_page[39:20]
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [39:0]       out_tdata;       // status[1:0], result_page[21:2], free_pages[32:22]

  int fail_count, replies_owed;
  int sent = 0, received = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int quiet_cycles = 0;

  // kind and effective order of each request in flight, in send order
  kind_t       kinds_sent[$];
  int          orders_sent[$];
  held_block_t held[$];
  held_block_t last_freed;

  buddy_page_allocator_core dut (.*);

  bpa_result_checker checker_i (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // receiver side: stall at random per the current phase
  always @(negedge clk)
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // track granted blocks so frees can hand them back; an init wipes them
  always @(posedge clk) begin
    kind_t k;
    int o;
    if (out_tvalid && out_tready && kinds_sent.size() > 0) begin
      received++;
      k = kinds_sent.pop_front();
      o = orders_sent.pop_front();
      if (k == KIND_INIT) held.delete();
      else if ((k == KIND_ALLOC || k == KIND_COUNT) && out_tdata[1:0] == ST_DONE)
        held.push_back('{out_tdata[21:2], o});
    end
  end

  // watchdog: count cycles in which no transfer happens on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, longint val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we    <= 0;
  endtask

  // one request transfer; unused fields carry random noise
  task automatic send(kind_t k, int ord, int cnt, longint page);
    logic [39:0] d;
    int eff;
    d = 40'({$urandom(), $urandom()});
    if (k == KIND_ALLOC || k == KIND_FREE) d[3:0] = 4'(ord);
    if (k == KIND_COUNT) d[19:4] = 16'(cnt);
    if (k == KIND_FREE) d[39:20] = 20'(page);
    eff = (k == KIND_COUNT) ? ((cnt > 1024 || cnt == 0) ? 11 : $clog2(cnt)) : int'(d[3:0]);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= k;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    kinds_sent.push_back(k);
    orders_sent.push_back(eff);
    sent++;
    @(negedge clk);
  endtask

  // hold until every reply is back, then give the sequencer time to settle
  task automatic drain();
    in_tvalid <= 0;
    while (received != sent) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic random_item();
    int r, i;
    held_block_t b;
    r = $urandom_range(0, 99);
    if (r < 3) send(KIND_INIT, 0, 0, 0);
    else if (r < 40)
      send(KIND_ALLOC, ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4)
                                                 : $urandom_range(0, 15), 0, 0);
    else if (r < 55)
      send(KIND_COUNT, 0, ($urandom_range(0, 9) < 8) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, 65535), 0);
    else if (r < 92 && held.size() > 0) begin
      i = $urandom_range(0, held.size() - 1);
      b = held[i];
      held.delete(i);
      last_freed = b;
      send(KIND_FREE, b.ord, 0, b.page);
    end else if (r < 98 || last_freed.page == 0)
      send(KIND_FREE, $urandom_range(0, 15), 0, {$urandom()} & 20'hFFFFF);
    else
      // double free of the block handed back last
      send(KIND_FREE, last_freed.ord, 0, last_freed.page);
  endtask

  initial begin
    longint bases [6] = '{0, 20'hFFFFF, 20'hFFE00, 37, 0, 0};
    longint counts[6] = '{1024, 2047, 1024, 1000, 0, 0};
    last_freed = '{0, 0};
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, every kind, rejections and a double free
    write_reg(REG_BASE, 0);
    write_reg(REG_PAGES, 1024);
    send(KIND_INIT, 0, 0, 0);
    send(KIND_ALLOC, 0, 0, 0);         // frame zero handed out
    send(KIND_ALLOC, 10, 0, 0);        // top order gone after the split
    send(KIND_ALLOC, 11, 0, 0);
    send(KIND_ALLOC, 15, 0, 0);
    send(KIND_COUNT, 0, 0, 0);
    send(KIND_COUNT, 0, 1, 0);
    send(KIND_COUNT, 0, 1025, 0);
    send(KIND_COUNT, 0, 65535, 0);
    send(KIND_COUNT, 0, 3, 0);
    send(KIND_FREE, 0, 0, 0);          // frame zero refused
    send(KIND_FREE, 0, 0, 1);
    send(KIND_FREE, 0, 0, 1);          // double free
    send(KIND_FREE, 2, 0, 5);          // misaligned
    send(KIND_FREE, 1, 0, 1023);
    send(KIND_FREE, 0, 0, 1024);       // past the managed run
    send(KIND_FREE, 2, 0, 4);
    send(KIND_FREE, 15, 0, 20'hFFFFF);
    drain();
    write_reg(REG_BASE, 100);
    write_reg(REG_PAGES, 50);
    send(KIND_ALLOC, 0, 0, 0);         // registers not yet latched
    send(KIND_INIT, 0, 0, 0);
    send(KIND_FREE, 0, 0, 99);         // below the base
    send(KIND_FREE, 2, 0, 148);        // runs off the end
    send(KIND_COUNT, 0, 50, 0);
    drain();

    // random segments, each with its own setting and one of four idle patterns
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 5) begin
        bases[5]  = $urandom_range(1, 20'hFFFFF);
        counts[5] = $urandom_range(1, 1024);
      end
      write_reg(REG_BASE, bases[seg]);
      write_reg(REG_PAGES, counts[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      send(KIND_INIT, 0, 0, 0);
      repeat (312) random_item();
      drain();
    end

    if (fail_count == 0 && replies_owed == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
